// ----- rtl/can_send_command_parser_unit_defines.svh -----
// Assertion shorthands for the command parser. Every check is sampled on
// the rising edge of clock and is switched off while reset is high.
`ifndef CAN_SEND_COMMAND_PARSER_UNIT_DEFINES_SVH
`define CAN_SEND_COMMAND_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSCP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cscp_pkg.sv -----
package cscp_pkg;

   // Result status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_CMD  = 3'd1;
   localparam logic [2:0] ST_BAD_LEN  = 3'd2;
   localparam logic [2:0] ST_ID_RANGE = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;

   localparam int unsigned WORD_LEN = 7;
   localparam logic [7:0] CMD_WORD [WORD_LEN] = '{8'h41, 8'h54, 8'h53, 8'h4D,
                                                   8'h43, 8'h41, 8'h4E};

   localparam logic [4:0]  MAX_VALUE_CHARS = 5'd16;
   localparam logic [15:0] MAX_STD_ID      = 16'd2047;
   localparam logic [10:0] HELD_ID_RESET   = 11'h0FF;
   localparam logic [4:0]  HEX_NONE        = 5'd16;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [10:0] can_id;
      logic [63:0] payload;
      logic        payload_updated;
   } rsp_payload_type;

   // Value of a hex digit, or HEX_NONE for any other character.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] d;
      if (c inside {[8'h30:8'h39]}) begin
         d = 5'(c - 8'd48);
      end else if (c inside {[8'h41:8'h46]}) begin
         d = 5'(c - 8'd55);
      end else if (c inside {[8'h61:8'h66]}) begin
         d = 5'(c - 8'd87);
      end else begin
         d = HEX_NONE;
      end
      return d;
   endfunction

endpackage

// ----- rtl/cscp_channel_if.sv -----
// Request channel: one received character per beat.
interface cscp_req_if;
   logic                     valid;
   logic                     ready;
   cscp_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// Response channel: one parse result per beat.
interface cscp_rsp_if;
   logic                     valid;
   logic                     ready;
   cscp_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/can_send_command_parser_unit.sv -----
// Channel   Direction  Beat contents
// --------  ---------  ---------------------------------------------------
// req_if    in         rx_byte: one ASCII character, carriage return ends
// rsp_if    out        status, can_id, payload, payload_updated per line
//
// One character is taken per clock cycle when nothing is stalled. A byte is
// parsed from the input register; a carriage return waits there until the
// response register is free, and the result beat is then posted there.
// Synchronous active-high reset clears the line state, sets the held
// identifier to 0x0FF and the held payload to zero.
// Only a carriage return waits on the response register: while a result is
// unclaimed, ordinary characters keep flowing and a second carriage return
// waits in the input register.
`include "can_send_command_parser_unit_defines.svh"

module can_send_command_parser_unit #(
   parameter int LINE_LIMIT = 30
) (
   input logic        clock,
   input logic        reset,
   cscp_req_if.sink   req_if,
   cscp_rsp_if.source rsp_if
);

   // The line counter saturates at one past the limit, which marks overflow.
   localparam int LEN_W = $clog2(LINE_LIMIT + 2);

   typedef enum logic [1:0] {
      PH_WORD,
      PH_ID,
      PH_VALUE,
      PH_SKIP
   } phase_type;

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;

   // Per-line parser state.
   phase_type   phase_ff, phase_in;
   logic [2:0]  match_pos_ff, match_pos_in;
   logic        mismatch_ff, mismatch_in;
   logic        id_started_ff, id_started_in;
   logic [15:0] id_accum_ff, id_accum_in;
   logic [63:0] value_ff, value_in;
   logic [4:0]  value_len_ff, value_len_in;
   logic [LEN_W-1:0] line_len_ff, line_len_in;

   // Values held across lines.
   logic [63:0] held_payload_ff, held_payload_in;
   logic [10:0] held_id_ff, held_id_in;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   cscp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic       is_cr;
   logic       rsp_free;
   logic       take;
   logic [4:0] digit;
   logic [2:0] status;
   logic       updated;

   assign is_cr    = (in_byte_ff == cscp_pkg::CHAR_CR);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   // The held byte is parsed this cycle unless it closes a line and the
   // previous result has not yet been taken.
   assign take     = in_valid_ff && (!is_cr || rsp_free);
   assign digit    = cscp_pkg::hex_value(in_byte_ff);

   assign req_if.ready   = !in_valid_ff || take;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_if.valid && req_if.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.payload.rx_byte;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      match_pos_in    = match_pos_ff;
      mismatch_in     = mismatch_ff;
      id_started_in   = id_started_ff;
      id_accum_in     = id_accum_ff;
      value_in        = value_ff;
      value_len_in    = value_len_ff;
      line_len_in     = line_len_ff;
      held_payload_in = held_payload_ff;
      held_id_in      = held_id_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in     = rsp_data_ff;
      status          = cscp_pkg::ST_OK;
      updated         = 1'b0;

      if (take && is_cr) begin
         // Close the line: grade it, update the held values, post a result.
         if (line_len_ff > LEN_W'(LINE_LIMIT)) begin
            status = cscp_pkg::ST_OVERFLOW;
         end else if (phase_ff != PH_VALUE || value_len_ff == 5'd0) begin
            status = cscp_pkg::ST_BAD_CMD;
         end else if (value_len_ff > cscp_pkg::MAX_VALUE_CHARS) begin
            status = cscp_pkg::ST_BAD_LEN;
         end else begin
            held_payload_in = value_ff;
            updated         = 1'b1;
            if (id_accum_ff > cscp_pkg::MAX_STD_ID) begin
               status = cscp_pkg::ST_ID_RANGE;
            end else begin
               held_id_in = id_accum_ff[10:0];
               status     = cscp_pkg::ST_OK;
            end
         end
         rsp_valid_in                = 1'b1;
         rsp_data_in.status          = status;
         rsp_data_in.can_id          = held_id_in;
         rsp_data_in.payload         = held_payload_in;
         rsp_data_in.payload_updated = updated;

         phase_in      = PH_WORD;
         match_pos_in  = 3'd0;
         mismatch_in   = 1'b0;
         id_started_in = 1'b0;
         id_accum_in   = 16'd0;
         value_in      = 64'd0;
         value_len_in  = 5'd0;
         line_len_in   = '0;
      end else if (take) begin
         if (line_len_ff <= LEN_W'(LINE_LIMIT)) begin
            line_len_in = line_len_ff + LEN_W'(1);
         end
         case (phase_ff)
            PH_WORD: begin
               if (in_byte_ff == cscp_pkg::CHAR_EQUALS) begin
                  // An equals sign before any word character is skipped.
                  if (match_pos_ff == 3'd0 && !mismatch_ff) begin
                     phase_in = PH_WORD;
                  end else if (!mismatch_ff &&
                               match_pos_ff == 3'(cscp_pkg::WORD_LEN)) begin
                     phase_in = PH_ID;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else if (!mismatch_ff &&
                            match_pos_ff < 3'(cscp_pkg::WORD_LEN) &&
                            in_byte_ff == cscp_pkg::CMD_WORD[match_pos_ff]) begin
                  match_pos_in = match_pos_ff + 3'd1;
               end else begin
                  mismatch_in = 1'b1;
               end
            end
            PH_ID: begin
               // Commas ahead of the first id character are skipped.
               if (in_byte_ff == cscp_pkg::CHAR_COMMA) begin
                  if (id_started_ff) begin
                     phase_in = PH_VALUE;
                  end
               end else begin
                  id_started_in = 1'b1;
                  if (digit != cscp_pkg::HEX_NONE) begin
                     id_accum_in = {id_accum_ff[11:0], digit[3:0]};
                  end
               end
            end
            PH_VALUE: begin
               if (value_len_ff <= cscp_pkg::MAX_VALUE_CHARS) begin
                  value_len_in = value_len_ff + 5'd1;
               end
               if (digit != cscp_pkg::HEX_NONE) begin
                  value_in = {value_ff[59:0], digit[3:0]};
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         phase_ff        <= PH_WORD;
         match_pos_ff    <= 3'd0;
         mismatch_ff     <= 1'b0;
         id_started_ff   <= 1'b0;
         id_accum_ff     <= 16'd0;
         value_ff        <= 64'd0;
         value_len_ff    <= 5'd0;
         line_len_ff     <= '0;
         held_payload_ff <= 64'd0;
         held_id_ff      <= cscp_pkg::HELD_ID_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         phase_ff        <= phase_in;
         match_pos_ff    <= match_pos_in;
         mismatch_ff     <= mismatch_in;
         id_started_ff   <= id_started_in;
         id_accum_ff     <= id_accum_in;
         value_ff        <= value_in;
         value_len_ff    <= value_len_in;
         line_len_ff     <= line_len_in;
         held_payload_ff <= held_payload_in;
         held_id_ff      <= held_id_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A good line always rewrites the payload.
   `CSCP_ASSERT_SAME(a_ok_updates,
      rsp_valid_ff && rsp_data_ff.status == cscp_pkg::ST_OK,
      rsp_data_ff.payload_updated, "status ok without payload update")
   // The payload is rewritten only for a good line or an out-of-range id.
   `CSCP_ASSERT_SAME(a_update_status, rsp_valid_ff && rsp_data_ff.payload_updated,
      rsp_data_ff.status == cscp_pkg::ST_OK || rsp_data_ff.status == cscp_pkg::ST_ID_RANGE,
      "payload update with a failing status")
   // A closed line leaves a clean slate behind it.
   `CSCP_ASSERT_NEXT(a_line_clear, take && is_cr,
      phase_ff == PH_WORD && line_len_ff == '0 && value_len_ff == 5'd0,
      "line state not cleared after carriage return")
   // The line counter never runs past its overflow mark.
   `CSCP_ASSERT_SAME(a_len_cap, 1'b1, line_len_ff <= LEN_W'(LINE_LIMIT + 1),
      "line counter beyond its saturation point")

endmodule
